>>> hdl/line_line_intersection_macros.svh
// Assertion macros for the line intersection RTL.
// Depends on nothing; included by line_line_intersection.sv, which carries concurrent assertions.
`ifndef LINE_LINE_INTERSECTION_MACROS_SVH
`define LINE_LINE_INTERSECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LLI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line intersection check failed");

// Next-cycle implication, disabled during reset.
`define LLI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line intersection check failed");

`endif

>>> hdl/lli_pkg.sv
// Types, widths and helper functions for the line intersection pipeline.
// Depends on nothing; used by lli_div and line_line_intersection.
package lli_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int OUT_WIDTH   = 24;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int DET_W       = PROD_W + 1;
   localparam int PA_W        = 2 * COORD_WIDTH;
   localparam int CROSS_W     = PA_W + 1;
   localparam int PN_W        = CROSS_W + DIFF_W;
   localparam int NUM_W       = PN_W + 1;
   localparam int TRIAL_W     = DET_W + OUT_WIDTH;
   localparam int DIV_STEPS   = OUT_WIDTH;
   localparam int STEP_W      = $clog2(OUT_WIDTH);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;

   typedef enum logic [1:0] {
      KIND_NONE       = 2'd0,
      KIND_POINT      = 2'd1,
      KIND_COINCIDENT = 2'd2
   } meet_kind_type;

   typedef struct packed {
      diff_type  dax, day, dbx, dby, ex, ey;
      coord_type ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   } s1_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] pdet1, pdet2, po1, po2;
      logic signed [PA_W-1:0]   pa1, pa2, pb1, pb2;
      diff_type                 dax, day, dbx, dby;
   } s2_type;

   typedef struct packed {
      logic signed [DET_W-1:0]   det;
      logic signed [CROSS_W-1:0] ca, cb;
      diff_type                  dax, day, dbx, dby;
      meet_kind_type             kind;
   } s3_type;

   typedef struct packed {
      logic signed [PN_W-1:0]  pxa, pxb, pya, pyb;
      logic signed [DET_W-1:0] det;
      meet_kind_type           kind;
   } s4_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] nx, ny;
      logic signed [DET_W-1:0] det;
      meet_kind_type           kind;
   } s5_type;

   typedef struct packed {
      logic [NUM_W-1:0] mag_x, mag_y;
      logic [DET_W-1:0] den;
      logic             neg_x, neg_y;
      meet_kind_type    kind;
   } s6_type;

   typedef struct packed {
      logic [NUM_W-1:0]     rem_x, rem_y;
      logic [DET_W-1:0]     den;
      logic [OUT_WIDTH-1:0] q_x, q_y;
      logic                 neg_x, neg_y, ovf_x, ovf_y;
      meet_kind_type        kind;
   } div_item_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] value;
      logic                 clip;
   } sat_type;

   // One restoring step on both quotients at the given bit position.
   function automatic div_item_type div_step(div_item_type it, logic [STEP_W-1:0] bitpos);
      div_item_type        r;
      logic [TRIAL_W-1:0]  trial;
      logic                bx, by;
      r     = it;
      trial = TRIAL_W'(it.den) << bitpos;
      bx    = TRIAL_W'(it.rem_x) >= trial;
      by    = TRIAL_W'(it.rem_y) >= trial;
      if (bx) begin
         r.rem_x = it.rem_x - trial[NUM_W-1:0];
      end
      if (by) begin
         r.rem_y = it.rem_y - trial[NUM_W-1:0];
      end
      r.q_x = {it.q_x[OUT_WIDTH-2:0], bx};
      r.q_y = {it.q_y[OUT_WIDTH-2:0], by};
      return r;
   endfunction

   // Apply sign and clamp to the signed output range.
   function automatic sat_type saturate(logic [OUT_WIDTH-1:0] q, logic neg, logic ovf);
      sat_type              r;
      logic [OUT_WIDTH-1:0] limit;
      logic [OUT_WIDTH-1:0] mag;
      limit = neg ? {1'b1, {(OUT_WIDTH-1){1'b0}}} : {1'b0, {(OUT_WIDTH-1){1'b1}}};
      if (ovf || (q > limit)) begin
         mag    = limit;
         r.clip = 1'b1;
      end else begin
         mag    = q;
         r.clip = 1'b0;
      end
      r.value = neg ? (~mag + OUT_WIDTH'(1)) : mag;
      return r;
   endfunction

endpackage

>>> hdl/line_line_intersection.sv
// Top level of the two-point line intersection pipeline.
// Depends on lli_pkg, lli_div and line_line_intersection_macros.svh.
//
//   channel | ports  | direction | carries
//   --------+--------+-----------+------------------------------------------
//   request | req_*  | in        | two lines, four points, signed Q11.4
//   result  | rsp_*  | out       | kind, crossing point Q19.4, clip flag
//
// One transaction enters per cycle while req_stall is low. It passes 32
// registers: seven arithmetic stages, 24 divider stages (one quotient bit
// each) and the output register. The 24-step restoring divider sets depth.
// Reset is synchronous and clears only the valid bits.
// A stall moves back stage by stage: a stage advances when it is empty or
// the stage after it advances, so bubbles are squeezed out.
module line_line_intersection (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lli_pkg::coord_type         req_line_a_x1,
   input  lli_pkg::coord_type         req_line_a_y1,
   input  lli_pkg::coord_type         req_line_a_x2,
   input  lli_pkg::coord_type         req_line_a_y2,
   input  lli_pkg::coord_type         req_line_b_x1,
   input  lli_pkg::coord_type         req_line_b_y1,
   input  lli_pkg::coord_type         req_line_b_x2,
   input  lli_pkg::coord_type         req_line_b_y2,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_meet_kind,
   output logic signed [lli_pkg::OUT_WIDTH-1:0] rsp_cross_x,
   output logic signed [lli_pkg::OUT_WIDTH-1:0] rsp_cross_y,
   output logic                       rsp_clipped
);
   import lli_pkg::*;

   s1_type        s1_ff;
   s2_type        s2_ff;
   s3_type        s3_ff;
   s4_type        s4_ff;
   s5_type        s5_ff;
   s6_type        s6_ff;
   div_item_type  s7_ff;
   div_item_type  s1_in_dummy;
   logic [7:1]    v_ff;
   logic [7:1]    adv;
   logic          div_in_stall;
   logic          div_valid;
   div_item_type  div_item;
   logic          rsp_adv;
   logic          rsp_valid_ff;
   meet_kind_type kind_ff;
   logic signed [OUT_WIDTH-1:0] cross_x_ff, cross_y_ff;
   logic          clipped_ff;
   sat_type       sat_x, sat_y;

   s1_type        s1_in;
   s2_type        s2_in;
   s3_type        s3_in;
   s4_type        s4_in;
   s5_type        s5_in;
   s6_type        s6_in;
   div_item_type  s7_in;

   // Handshake chain: advance a stage when it is empty or its successor moves.
   assign rsp_adv = !rsp_valid_ff || !rsp_stall;
   assign adv[7]  = !v_ff[7] || !div_in_stall;
   assign adv[6]  = !v_ff[6] || adv[7];
   assign adv[5]  = !v_ff[5] || adv[6];
   assign adv[4]  = !v_ff[4] || adv[5];
   assign adv[3]  = !v_ff[3] || adv[4];
   assign adv[2]  = !v_ff[2] || adv[3];
   assign adv[1]  = !v_ff[1] || adv[2];
   assign req_stall = !adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) v_ff[1] <= req_valid;
         if (adv[2]) v_ff[2] <= v_ff[1];
         if (adv[3]) v_ff[3] <= v_ff[2];
         if (adv[4]) v_ff[4] <= v_ff[3];
         if (adv[5]) v_ff[5] <= v_ff[4];
         if (adv[6]) v_ff[6] <= v_ff[5];
         if (adv[7]) v_ff[7] <= v_ff[6];
      end
   end

   // Stage 1: direction vectors and the A1-B1 offset.
   always_comb begin
      s1_in.ax1 = req_line_a_x1;
      s1_in.ay1 = req_line_a_y1;
      s1_in.ax2 = req_line_a_x2;
      s1_in.ay2 = req_line_a_y2;
      s1_in.bx1 = req_line_b_x1;
      s1_in.by1 = req_line_b_y1;
      s1_in.bx2 = req_line_b_x2;
      s1_in.by2 = req_line_b_y2;
      s1_in.dax = DIFF_W'(req_line_a_x1) - DIFF_W'(req_line_a_x2);
      s1_in.day = DIFF_W'(req_line_a_y1) - DIFF_W'(req_line_a_y2);
      s1_in.dbx = DIFF_W'(req_line_b_x1) - DIFF_W'(req_line_b_x2);
      s1_in.dby = DIFF_W'(req_line_b_y1) - DIFF_W'(req_line_b_y2);
      s1_in.ex  = DIFF_W'(req_line_a_x1) - DIFF_W'(req_line_b_x1);
      s1_in.ey  = DIFF_W'(req_line_a_y1) - DIFF_W'(req_line_b_y1);
   end

   // Stage 2: all first-level products. The offset cross product is taken
   // with flipped sign; only its zero test matters.
   always_comb begin
      s2_in.pdet1 = PROD_W'(s1_ff.dax) * PROD_W'(s1_ff.dby);
      s2_in.pdet2 = PROD_W'(s1_ff.day) * PROD_W'(s1_ff.dbx);
      s2_in.po1   = PROD_W'(s1_ff.dax) * PROD_W'(s1_ff.ey);
      s2_in.po2   = PROD_W'(s1_ff.ex) * PROD_W'(s1_ff.day);
      s2_in.pa1   = PA_W'(s1_ff.ax1) * PA_W'(s1_ff.ay2);
      s2_in.pa2   = PA_W'(s1_ff.ay1) * PA_W'(s1_ff.ax2);
      s2_in.pb1   = PA_W'(s1_ff.bx1) * PA_W'(s1_ff.by2);
      s2_in.pb2   = PA_W'(s1_ff.by1) * PA_W'(s1_ff.bx2);
      s2_in.dax   = s1_ff.dax;
      s2_in.day   = s1_ff.day;
      s2_in.dbx   = s1_ff.dbx;
      s2_in.dby   = s1_ff.dby;
   end

   // Stage 3: determinant, line constants and the kind decision.
   always_comb begin
      s3_in.det = DET_W'(s2_ff.pdet1) - DET_W'(s2_ff.pdet2);
      s3_in.ca  = CROSS_W'(s2_ff.pa1) - CROSS_W'(s2_ff.pa2);
      s3_in.cb  = CROSS_W'(s2_ff.pb1) - CROSS_W'(s2_ff.pb2);
      s3_in.dax = s2_ff.dax;
      s3_in.day = s2_ff.day;
      s3_in.dbx = s2_ff.dbx;
      s3_in.dby = s2_ff.dby;
      priority if (s2_ff.pdet1 != s2_ff.pdet2) begin
         s3_in.kind = KIND_POINT;
      end else if ((s2_ff.dax != '0 || s2_ff.day != '0) && s2_ff.po1 == s2_ff.po2) begin
         s3_in.kind = KIND_COINCIDENT;
      end else begin
         s3_in.kind = KIND_NONE;
      end
   end

   // Stage 4: numerator products.
   always_comb begin
      s4_in.pxa  = PN_W'(s3_ff.ca) * PN_W'(s3_ff.dbx);
      s4_in.pxb  = PN_W'(s3_ff.dax) * PN_W'(s3_ff.cb);
      s4_in.pya  = PN_W'(s3_ff.ca) * PN_W'(s3_ff.dby);
      s4_in.pyb  = PN_W'(s3_ff.day) * PN_W'(s3_ff.cb);
      s4_in.det  = s3_ff.det;
      s4_in.kind = s3_ff.kind;
   end

   // Stage 5: Cramer numerators.
   always_comb begin
      s5_in.nx   = NUM_W'(s4_ff.pxa) - NUM_W'(s4_ff.pxb);
      s5_in.ny   = NUM_W'(s4_ff.pya) - NUM_W'(s4_ff.pyb);
      s5_in.det  = s4_ff.det;
      s5_in.kind = s4_ff.kind;
   end

   // Stage 6: strip signs for the unsigned divider.
   always_comb begin
      s6_in.mag_x = s5_ff.nx[NUM_W-1] ? NUM_W'(-s5_ff.nx) : NUM_W'(s5_ff.nx);
      s6_in.mag_y = s5_ff.ny[NUM_W-1] ? NUM_W'(-s5_ff.ny) : NUM_W'(s5_ff.ny);
      s6_in.den   = s5_ff.det[DET_W-1] ? DET_W'(-s5_ff.det) : DET_W'(s5_ff.det);
      s6_in.neg_x = s5_ff.nx[NUM_W-1] ^ s5_ff.det[DET_W-1];
      s6_in.neg_y = s5_ff.ny[NUM_W-1] ^ s5_ff.det[DET_W-1];
      s6_in.kind  = s5_ff.kind;
   end

   // Stage 7: flag quotients of 2^OUT_WIDTH or more; the divider then only
   // has to produce OUT_WIDTH quotient bits.
   always_comb begin
      s7_in.rem_x = s6_ff.mag_x;
      s7_in.rem_y = s6_ff.mag_y;
      s7_in.den   = s6_ff.den;
      s7_in.q_x   = '0;
      s7_in.q_y   = '0;
      s7_in.neg_x = s6_ff.neg_x;
      s7_in.neg_y = s6_ff.neg_y;
      s7_in.ovf_x = TRIAL_W'(s6_ff.mag_x) >= {s6_ff.den, {OUT_WIDTH{1'b0}}};
      s7_in.ovf_y = TRIAL_W'(s6_ff.mag_y) >= {s6_ff.den, {OUT_WIDTH{1'b0}}};
      s7_in.kind  = s6_ff.kind;
   end

   assign s1_in_dummy = s7_in;

   always_ff @(posedge clock) begin
      if (adv[1]) s1_ff <= s1_in;
      if (adv[2]) s2_ff <= s2_in;
      if (adv[3]) s3_ff <= s3_in;
      if (adv[4]) s4_ff <= s4_in;
      if (adv[5]) s5_ff <= s5_in;
      if (adv[6]) s6_ff <= s6_in;
      if (adv[7]) s7_ff <= s1_in_dummy;
   end

   lli_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_ff[7]),
      .in_stall  (div_in_stall),
      .in_item   (s7_ff),
      .out_valid (div_valid),
      .out_stall (!rsp_adv),
      .out_item  (div_item)
   );

   // Output register: sign, clamp, and drop the point unless it is a single one.
   assign sat_x = saturate(div_item.q_x, div_item.neg_x, div_item.ovf_x);
   assign sat_y = saturate(div_item.q_y, div_item.neg_y, div_item.ovf_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_adv) begin
         kind_ff <= div_item.kind;
         if (div_item.kind == KIND_POINT) begin
            cross_x_ff <= sat_x.value;
            cross_y_ff <= sat_y.value;
            clipped_ff <= sat_x.clip | sat_y.clip;
         end else begin
            cross_x_ff <= '0;
            cross_y_ff <= '0;
            clipped_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_meet_kind = kind_ff;
   assign rsp_cross_x   = cross_x_ff;
   assign rsp_cross_y   = cross_y_ff;
   assign rsp_clipped   = clipped_ff;

`include "line_line_intersection_macros.svh"

   `LLI_ASSERT_NOW(a_zero_unless_point, clock, reset,
      rsp_valid_ff && kind_ff != KIND_POINT,
      cross_x_ff == '0 && cross_y_ff == '0 && !clipped_ff)
   `LLI_ASSERT_NOW(a_clip_at_rail, clock, reset,
      rsp_valid_ff && clipped_ff,
      cross_x_ff == {1'b1, {(OUT_WIDTH-1){1'b0}}} || cross_x_ff == {1'b0, {(OUT_WIDTH-1){1'b1}}}
      || cross_y_ff == {1'b1, {(OUT_WIDTH-1){1'b0}}} || cross_y_ff == {1'b0, {(OUT_WIDTH-1){1'b1}}})
   `LLI_ASSERT_NEXT(a_accept_fills_s1, clock, reset,
      req_valid && !req_stall, v_ff[1])

endmodule

>>> hdl/lli_div.sv
// Pipelined restoring divider, one quotient bit per stage, for x and y at once.
// Depends on lli_pkg.
module lli_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  lli_pkg::div_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_stall,
   output lli_pkg::div_item_type out_item
);
   import lli_pkg::*;

   div_item_type           stage_ff [DIV_STEPS];
   div_item_type           prev_item [DIV_STEPS];
   logic [DIV_STEPS-1:0]   valid_ff;
   logic [DIV_STEPS-1:0]   prev_valid;
   logic [DIV_STEPS-1:0]   adv;

   assign adv[DIV_STEPS-1] = !valid_ff[DIV_STEPS-1] || !out_stall;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      if (k == 0) begin : g_first
         assign prev_item[k]  = in_item;
         assign prev_valid[k] = in_valid;
      end else begin : g_rest
         assign prev_item[k]  = stage_ff[k-1];
         assign prev_valid[k] = valid_ff[k-1];
      end
      if (k < DIV_STEPS - 1) begin : g_adv
         assign adv[k] = !valid_ff[k] || adv[k+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= prev_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            stage_ff[k] <= div_step(prev_item[k], STEP_W'(OUT_WIDTH - 1 - k));
         end
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_item  = stage_ff[DIV_STEPS-1];

endmodule
